### sv/grm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// grm_pkg
// Shared widths, constants, command and status types for the grid ray marcher.
// ----------------------------------------------------------------------------
package grm_pkg;

    // Fixed-point format and angle resolution
    localparam int ANGLE_BITS    = 12;
    localparam int FRAC_BITS     = 16;

    // Defaults for the top-level parameters
    localparam int MAP_DIM_DEF   = 64;
    localparam int MAX_STEPS_DEF = 128;

    // Port field widths
    localparam int POS_IN_W  = 22;
    localparam int ANG_IN_W  = 12;
    localparam int CELL_IN_W = 6;

    // Internal widths
    localparam int POS_W   = FRAC_BITS + ANGLE_BITS + 12;  // signed ray position
    localparam int CRD_W   = POS_W - FRAC_BITS;            // signed cell coordinate
    localparam int DX_W    = FRAC_BITS + 2;                // signed gap to next border
    localparam int MAG_W   = FRAC_BITS + 1;                // gap magnitude
    localparam int TRIG_W  = 34;                           // signed Q4.30 cos / sin
    localparam int TMAG_W  = 31;                           // cos / sin magnitude
    localparam int PROD_W  = MAG_W + TMAG_W;
    localparam int QB      = FRAC_BITS + ANGLE_BITS - 1;   // quotient bits
    localparam int QCNT_W  = $clog2(QB + 1);
    localparam int REM_W   = TMAG_W + 1;
    localparam int Z_W     = 33;
    localparam int ROT_ITERS = 16;
    localparam int IT_W      = 4;

    localparam logic signed [TRIG_W-1:0] CORDIC_GAIN = TRIG_W'(652032874);
    localparam logic signed [TRIG_W-1:0] TRIG_ONE    = TRIG_W'(64'd1 << 30);
    localparam logic signed [Z_W-1:0]    Z_EIGHTH    = Z_W'(64'h2000_0000);
    localparam logic [31:0]              PHASE_EIGHTH = 32'h2000_0000;
    localparam logic signed [POS_W-1:0]  POS_ONE     = POS_W'(64'd1 << FRAC_BITS);
    localparam logic signed [POS_W-1:0]  OUT_MAX     = POS_W'(64'h3F_FFFF);

    // Controller to datapath commands
    typedef struct packed {
        logic clr_step;
        logic map_write;
        logic load;
        logic rot_step;
        logic dir_latch;
        logic step_begin;
        logic mul_x;
        logic mul_y;
        logic div_start;
        logic div_step;
        logic move_y_only;
        logic move_both;
        logic apply_div;
        logic cell_latch;
        logic rd_corner;
        logic set_found;
        logic out_load;
    } grm_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic clr_last;
        logic rot_last;
        logic c_zero;
        logic take_x;
        logic equal;
        logic div_last;
        logic corner_need;
        logic main_inside;
        logic rd_wall;
        logic step_max;
    } grm_sts_t;

    // Arctangent of 2^-i in turns scaled by 2^32
    function automatic logic signed [Z_W-1:0] atan_lut(input logic [IT_W-1:0] idx);
        logic signed [Z_W-1:0] val;
        case (idx)
            4'd0:    val = Z_W'(536870912);
            4'd1:    val = Z_W'(316933406);
            4'd2:    val = Z_W'(167458908);
            4'd3:    val = Z_W'(85004756);
            4'd4:    val = Z_W'(42667331);
            4'd5:    val = Z_W'(21354465);
            4'd6:    val = Z_W'(10679838);
            4'd7:    val = Z_W'(5340244);
            4'd8:    val = Z_W'(2670159);
            4'd9:    val = Z_W'(1335087);
            4'd10:   val = Z_W'(667544);
            4'd11:   val = Z_W'(333772);
            4'd12:   val = Z_W'(166886);
            4'd13:   val = Z_W'(83443);
            4'd14:   val = Z_W'(41722);
            default: val = Z_W'(20861);
        endcase
        return val;
    endfunction

endpackage
`default_nettype wire

### sv/grid_ray_march.sv
// Write item: taken in idle, no result. Cast: direction setup (16 CORDIC
// rotations and a latch), then per border crossing the gaps, two cross products,
// a decision, a division where needed (QB = 27 divider iterations by default), a
// cell latch, a corner read at an exact corner and the main read. One item at a
// time; a finished result waits in the output register. Reset: a clearing pass
// writes every map cell open, s_tready low meanwhile.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// grid_ray_march
// Wall map with a fixed-point border-stepping ray caster.
// ----------------------------------------------------------------------------
module grid_ray_march #(
    parameter int MAP_DIM   = grm_pkg::MAP_DIM_DEF,
    parameter int MAX_STEPS = grm_pkg::MAX_STEPS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [21:0] start_x, [43:22] start_y, [55:44] angle, [61:56] cell_x,
    // [67:62] cell_y, [68] cell_wall, [71:69] zero
    input  wire logic [71:0] s_tdata,
    // [0] func
    input  wire logic        s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [21:0] hit_x, [43:22] hit_y, [47:44] zero
    output logic [47:0]      m_tdata,
    // [0] hit_face, [1] hit_found
    output logic [1:0]       m_tuser
);
    import grm_pkg::*;

    grm_cmd_t            cmd;
    grm_sts_t            sts;
    logic [POS_IN_W-1:0] hit_x, hit_y;
    logic                hit_face, hit_found;

    grm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_cast   (s_tuser),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .cmd       (cmd),
        .sts       (sts)
    );

    grm_dpath #(
        .MAP_DIM   (MAP_DIM),
        .MAX_STEPS (MAX_STEPS)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .start_x   (s_tdata[21:0]),
        .start_y   (s_tdata[43:22]),
        .angle     (s_tdata[55:44]),
        .cell_x    (s_tdata[61:56]),
        .cell_y    (s_tdata[67:62]),
        .cell_wall (s_tdata[68]),
        .hit_x     (hit_x),
        .hit_y     (hit_y),
        .hit_face  (hit_face),
        .hit_found (hit_found)
    );

    assign m_tdata = {4'b0000, hit_y, hit_x};
    assign m_tuser = {hit_found, hit_face};

`ifndef NO_ASSERTIONS
    // A new result never overwrites one still waiting for its transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !(m_tvalid && !m_tready))
        else $error("result overwritten before transfer");

    // Clearing and cell writes never share the write port
    assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.clr_step && (cmd.map_write || s_tready)))
        else $error("map write during clearing pass");

    // An accepted cast makes the block busy on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tuser) |=> (!s_tready && cmd.rot_step))
        else $error("cast not started");
`endif

endmodule
`default_nettype wire

### sv/grm_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// grm_ctrl
// Sequencer for map clearing, cell writes and the border-stepping ray cast.
// ----------------------------------------------------------------------------
module grm_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    input  wire logic             in_cast,
    output logic                  in_ready,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output grm_pkg::grm_cmd_t     cmd,
    input  wire grm_pkg::grm_sts_t sts
);
    import grm_pkg::*;

    typedef enum logic [15:0] {
        S_CLEAR  = 16'h0001,
        S_IDLE   = 16'h0002,
        S_ROT    = 16'h0004,
        S_DIR    = 16'h0008,
        S_STEP   = 16'h0010,
        S_MULX   = 16'h0020,
        S_MULY   = 16'h0040,
        S_DECIDE = 16'h0080,
        S_DIV    = 16'h0100,
        S_APPLY  = 16'h0200,
        S_CELL   = 16'h0400,
        S_RDC    = 16'h0800,
        S_EVC    = 16'h1000,
        S_RDM    = 16'h2000,
        S_EVM    = 16'h4000,
        S_DONE   = 16'h8000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_cast)
                    begin
                        cmd.load   = 1'b1;
                        state_next = S_ROT;
                    end
                    else
                        cmd.map_write = 1'b1;
                end
            end
            S_ROT:
            begin
                cmd.rot_step = 1'b1;
                if (sts.rot_last)
                    state_next = S_DIR;
            end
            S_DIR:
            begin
                cmd.dir_latch = 1'b1;
                state_next    = S_STEP;
            end
            S_STEP:
            begin
                cmd.step_begin = 1'b1;
                state_next     = S_MULX;
            end
            S_MULX:
            begin
                cmd.mul_x  = 1'b1;
                state_next = S_MULY;
            end
            S_MULY:
            begin
                cmd.mul_y  = 1'b1;
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                if (sts.c_zero)
                begin
                    cmd.move_y_only = 1'b1;
                    state_next      = S_CELL;
                end
                else if (sts.take_x || !sts.equal)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end
                else
                begin
                    cmd.move_both = 1'b1;
                    state_next    = S_CELL;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                    state_next = S_APPLY;
            end
            S_APPLY:
            begin
                cmd.apply_div = 1'b1;
                state_next    = S_CELL;
            end
            S_CELL:
            begin
                cmd.cell_latch = 1'b1;
                state_next     = sts.corner_need ? S_RDC : S_RDM;
            end
            S_RDC:
            begin
                cmd.rd_corner = 1'b1;
                state_next    = S_EVC;
            end
            S_EVC:
            begin
                if (sts.rd_wall)
                begin
                    cmd.set_found = 1'b1;
                    state_next    = S_DONE;
                end
                else
                    state_next = S_RDM;
            end
            S_RDM:
            begin
                state_next = sts.main_inside ? S_EVM : S_DONE;
            end
            S_EVM:
            begin
                if (sts.rd_wall)
                begin
                    cmd.set_found = 1'b1;
                    state_next    = S_DONE;
                end
                else if (sts.step_max)
                    state_next = S_DONE;
                else
                    state_next = S_STEP;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
                state_next = S_CLEAR;
        endcase
    end

    // Hold a finished result until its transfer
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        if (cmd.out_load)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule
`default_nettype wire

### sv/grm_dpath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// grm_dpath
// Wall map memory, CORDIC direction unit, border-step arithmetic with a
// shared multiplier and a radix-2 divider, and the result register.
// ----------------------------------------------------------------------------
module grm_dpath #(
    parameter int MAP_DIM   = grm_pkg::MAP_DIM_DEF,
    parameter int MAX_STEPS = grm_pkg::MAX_STEPS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire grm_pkg::grm_cmd_t             cmd,
    output grm_pkg::grm_sts_t                  sts,
    input  wire logic [grm_pkg::POS_IN_W-1:0]  start_x,
    input  wire logic [grm_pkg::POS_IN_W-1:0]  start_y,
    input  wire logic [grm_pkg::ANG_IN_W-1:0]  angle,
    input  wire logic [grm_pkg::CELL_IN_W-1:0] cell_x,
    input  wire logic [grm_pkg::CELL_IN_W-1:0] cell_y,
    input  wire logic                          cell_wall,
    output logic [grm_pkg::POS_IN_W-1:0]       hit_x,
    output logic [grm_pkg::POS_IN_W-1:0]       hit_y,
    output logic                               hit_face,
    output logic                               hit_found
);
    import grm_pkg::*;

    localparam int CW     = $clog2(MAP_DIM);
    localparam int ADDR_W = 2 * CW;
    localparam int DEPTH  = 1 << ADDR_W;
    localparam int SC_W   = $clog2(MAX_STEPS + 1);
    localparam logic signed [CRD_W-1:0] MAP_LIM = CRD_W'(MAP_DIM);

    // ------------------------------------------------------------------
    // Wall map
    // ------------------------------------------------------------------
    logic              map_mem [DEPTH];
    logic [ADDR_W-1:0] clr_addr_reg;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_in_map;
    logic              rd_data_reg;
    logic [ADDR_W-1:0] corner_addr_reg;
    logic [ADDR_W-1:0] main_addr_reg;

    assign wr_in_map = ({{(32-CELL_IN_W){1'b0}}, cell_x} < 32'(MAP_DIM)) &&
                       ({{(32-CELL_IN_W){1'b0}}, cell_y} < 32'(MAP_DIM));
    assign wr_addr   = {CW'(cell_y), CW'(cell_x)};
    assign rd_addr   = cmd.rd_corner ? corner_addr_reg : main_addr_reg;

    // Advance the clearing sweep
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_addr_reg <= '0;
        else if (cmd.clr_step)
            clr_addr_reg <= clr_addr_reg + 1'b1;
    end

    // Write and read the map
    always_ff @(posedge clk)
    begin
        if (cmd.clr_step)
            map_mem[clr_addr_reg] <= 1'b0;
        else if (cmd.map_write && wr_in_map)
            map_mem[wr_addr] <= cell_wall;
        rd_data_reg <= map_mem[rd_addr];
    end

    // ------------------------------------------------------------------
    // CORDIC direction
    // ------------------------------------------------------------------
    logic [31:0]              phase;
    logic [31:0]              phase_rot;
    logic signed [Z_W-1:0]    z_init;
    logic signed [TRIG_W-1:0] cx_reg, cy_reg;
    logic signed [Z_W-1:0]    z_reg;
    logic [1:0]               quad_reg;
    logic                     hold_reg;
    logic [IT_W-1:0]          it_reg;
    logic signed [TRIG_W-1:0] c_reg, s_reg;
    logic signed [TRIG_W-1:0] c_next, s_next;

    assign phase     = 32'(angle) << (32 - ANGLE_BITS);
    assign phase_rot = phase + PHASE_EIGHTH;
    assign z_init    = $signed({{(Z_W-30){1'b0}}, phase_rot[29:0]}) - Z_EIGHTH;

    // Rotate toward zero residual, one micro-rotation a cycle
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cx_reg   <= (z_init == '0) ? TRIG_ONE : CORDIC_GAIN;
            cy_reg   <= '0;
            z_reg    <= z_init;
            quad_reg <= phase_rot[31:30];
            hold_reg <= (z_init == '0);
            it_reg   <= '0;
        end
        else if (cmd.rot_step)
        begin
            it_reg <= it_reg + 1'b1;
            if (!hold_reg)
            begin
                if (!z_reg[Z_W-1])
                begin
                    cx_reg <= cx_reg - (cy_reg >>> it_reg);
                    cy_reg <= cy_reg + (cx_reg >>> it_reg);
                    z_reg  <= z_reg - atan_lut(it_reg);
                end
                else
                begin
                    cx_reg <= cx_reg + (cy_reg >>> it_reg);
                    cy_reg <= cy_reg - (cx_reg >>> it_reg);
                    z_reg  <= z_reg + atan_lut(it_reg);
                end
            end
        end
    end

    // Map the quadrant onto cos and sin
    always_comb
    begin
        case (quad_reg)
            2'd0:
            begin
                c_next = cx_reg;
                s_next = cy_reg;
            end
            2'd1:
            begin
                c_next = -cy_reg;
                s_next = cx_reg;
            end
            2'd2:
            begin
                c_next = -cx_reg;
                s_next = -cy_reg;
            end
            default:
            begin
                c_next = cy_reg;
                s_next = -cx_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.dir_latch)
        begin
            c_reg <= c_next;
            s_reg <= s_next;
        end
    end

    logic              c_neg, s_neg, c_pos, s_pos;
    logic [TMAG_W-1:0] c_mag, s_mag;

    assign c_neg = c_reg[TRIG_W-1];
    assign s_neg = s_reg[TRIG_W-1];
    assign c_pos = !c_neg && (c_reg != '0);
    assign s_pos = !s_neg && (s_reg != '0);
    assign c_mag = TMAG_W'(c_neg ? -c_reg : c_reg);
    assign s_mag = TMAG_W'(s_neg ? -s_reg : s_reg);

    // ------------------------------------------------------------------
    // Border step
    // ------------------------------------------------------------------
    logic signed [POS_W-1:0] px_reg, py_reg;
    logic signed [POS_W-1:0] nx_reg, ny_reg;
    logic signed [DX_W-1:0]  dx_reg, dy_reg;
    logic signed [POS_W-1:0] bx_fl, by_fl, nx_c, ny_c, dx_full, dy_full;
    logic [SC_W-1:0]         step_cnt_reg;

    assign bx_fl   = {px_reg[POS_W-1:FRAC_BITS], {FRAC_BITS{1'b0}}};
    assign by_fl   = {py_reg[POS_W-1:FRAC_BITS], {FRAC_BITS{1'b0}}};
    assign nx_c    = c_pos ? bx_fl + POS_ONE :
                     ((px_reg != bx_fl) ? bx_fl : bx_fl - POS_ONE);
    assign ny_c    = s_pos ? by_fl + POS_ONE :
                     ((py_reg != by_fl) ? by_fl : by_fl - POS_ONE);
    assign dx_full = nx_c - px_reg;
    assign dy_full = ny_c - py_reg;

    // Shared multiplier for both cross products
    logic [MAG_W-1:0]  dx_mag, dy_mag, mul_a;
    logic [TMAG_W-1:0] mul_b;
    logic [PROD_W-1:0] mul_p, ax_reg, ay_reg;

    assign dx_mag = MAG_W'(dx_reg[DX_W-1] ? -dx_reg : dx_reg);
    assign dy_mag = MAG_W'(dy_reg[DX_W-1] ? -dy_reg : dy_reg);
    assign mul_a  = cmd.mul_x ? dx_mag : dy_mag;
    assign mul_b  = cmd.mul_x ? s_mag : c_mag;
    assign mul_p  = PROD_W'(mul_a) * PROD_W'(mul_b);

    always_ff @(posedge clk)
    begin
        if (cmd.step_begin)
        begin
            nx_reg <= nx_c;
            ny_reg <= ny_c;
            dx_reg <= DX_W'(dx_full);
            dy_reg <= DX_W'(dy_full);
        end
        if (cmd.mul_x)
            ax_reg <= mul_p;
        if (cmd.mul_y)
            ay_reg <= mul_p;
    end

    // Radix-2 divider: quotient of the cross product by the other component
    logic [PROD_W-1:0] div_num;
    logic [TMAG_W-1:0] div_den;
    logic [REM_W-1:0]  rem_reg, rem_trial;
    logic [QB-1:0]     dsh_reg, q_reg;
    logic [QCNT_W-1:0] dcnt_reg;
    logic [TMAG_W-1:0] den_reg;
    logic              mode_x_reg, neg_reg;
    logic              q_bit;

    assign div_num   = sts.take_x ? ax_reg : ay_reg;
    assign div_den   = sts.take_x ? c_mag : s_mag;
    assign rem_trial = {rem_reg[REM_W-2:0], dsh_reg[QB-1]};
    assign q_bit     = rem_trial >= {1'b0, den_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            rem_reg    <= REM_W'(div_num[PROD_W-1:QB]);
            dsh_reg    <= div_num[QB-1:0];
            den_reg    <= div_den;
            q_reg      <= '0;
            dcnt_reg   <= QCNT_W'(QB);
            mode_x_reg <= sts.take_x;
            neg_reg    <= sts.take_x ? (dx_reg[DX_W-1] ^ s_neg ^ c_neg)
                                     : (dy_reg[DX_W-1] ^ s_neg ^ c_neg);
        end
        else if (cmd.div_step)
        begin
            rem_reg  <= q_bit ? rem_trial - {1'b0, den_reg} : rem_trial;
            dsh_reg  <= {dsh_reg[QB-2:0], 1'b0};
            q_reg    <= {q_reg[QB-2:0], q_bit};
            dcnt_reg <= dcnt_reg - 1'b1;
        end
    end

    logic signed [POS_W-1:0] q_ext, delta;

    assign q_ext = $signed(POS_W'(q_reg));
    assign delta = neg_reg ? -q_ext : q_ext;

    // Move the ray and count steps
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            px_reg       <= '0;
            py_reg       <= '0;
            step_cnt_reg <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                px_reg       <= $signed(POS_W'(start_x));
                py_reg       <= $signed(POS_W'(start_y));
                step_cnt_reg <= '0;
            end
            if (cmd.step_begin)
                step_cnt_reg <= step_cnt_reg + 1'b1;
            if (cmd.move_y_only)
                py_reg <= ny_reg;
            if (cmd.move_both)
            begin
                px_reg <= nx_reg;
                py_reg <= ny_reg;
            end
            if (cmd.apply_div)
            begin
                if (mode_x_reg)
                begin
                    px_reg <= nx_reg;
                    py_reg <= py_reg + delta;
                end
                else
                begin
                    px_reg <= px_reg + delta;
                    py_reg <= ny_reg;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Cell test
    // ------------------------------------------------------------------
    logic signed [CRD_W-1:0] bx_c, by_c, cx_c, cy_c, by_up;
    logic                    x_whole, y_whole, main_in, corner_in;
    logic                    face_reg, main_in_reg, found_reg;

    assign bx_c    = px_reg[POS_W-1:FRAC_BITS];
    assign by_c    = py_reg[POS_W-1:FRAC_BITS];
    assign by_up   = by_c - 1'b1;
    assign x_whole = (px_reg[FRAC_BITS-1:0] == '0);
    assign y_whole = (py_reg[FRAC_BITS-1:0] == '0);
    assign cx_c    = x_whole ? (c_pos ? bx_c : bx_c - 1'b1) : bx_c;
    assign cy_c    = x_whole ? by_c : (s_pos ? by_c : by_c - 1'b1);
    assign main_in = !cx_c[CRD_W-1] && (cx_c < MAP_LIM) &&
                     !cy_c[CRD_W-1] && (cy_c < MAP_LIM);
    assign corner_in = !cx_c[CRD_W-1] && (cx_c < MAP_LIM) &&
                       !by_up[CRD_W-1] && (by_up < MAP_LIM);

    always_ff @(posedge clk)
    begin
        if (cmd.cell_latch)
        begin
            face_reg        <= !x_whole;
            main_in_reg     <= main_in;
            main_addr_reg   <= {cy_c[CW-1:0], cx_c[CW-1:0]};
            corner_addr_reg <= {by_up[CW-1:0], cx_c[CW-1:0]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            found_reg <= 1'b0;
        else if (cmd.load)
            found_reg <= 1'b0;
        else if (cmd.set_found)
            found_reg <= 1'b1;
    end

    // ------------------------------------------------------------------
    // Result register with saturation
    // ------------------------------------------------------------------
    function automatic logic [POS_IN_W-1:0] sat_pos(input logic signed [POS_W-1:0] v);
        logic [POS_IN_W-1:0] r;
        if (v[POS_W-1])
            r = '0;
        else if (v > OUT_MAX)
            r = '1;
        else
            r = v[POS_IN_W-1:0];
        return r;
    endfunction

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            hit_x     <= sat_pos(px_reg);
            hit_y     <= sat_pos(py_reg);
            hit_face  <= face_reg;
            hit_found <= found_reg;
        end
    end

    // Status
    always_comb
    begin
        sts.clr_last    = &clr_addr_reg;
        sts.rot_last    = (it_reg == IT_W'(ROT_ITERS - 1));
        sts.c_zero      = (c_reg == '0);
        sts.take_x      = (s_reg == '0) || (ax_reg < ay_reg);
        sts.equal       = (ax_reg == ay_reg);
        sts.div_last    = (dcnt_reg == QCNT_W'(1));
        sts.corner_need = x_whole && y_whole && corner_in;
        sts.main_inside = main_in_reg;
        sts.rd_wall     = rd_data_reg;
        sts.step_max    = (step_cnt_reg == SC_W'(MAX_STEPS));
    end

endmodule
`default_nettype wire

### bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for grid_ray_march: map writes and ray casts go in
// over the input stream, and each cast result is matched field by field
// against a fixed-point ray walk kept inside the bench.
// ----------------------------------------------------------------------------
module tb;
    import grm_pkg::*;

    localparam int      MAP_N       = 64;
    localparam int      STEP_LIMIT  = 128;
    localparam longint  UNIT        = 64'sd1 << FRAC_BITS;
    localparam longint  POS_MAX     = 64'sh3F_FFFF;
    localparam longint  GAIN        = 652032874;
    localparam longint  CYCLE_LIMIT = 40_000_000;
    localparam bit      OP_WRITE    = 1'b0;
    localparam bit      OP_CAST     = 1'b1;
    localparam longint  ARC_TURNS [16] = '{
        536870912, 316933406, 167458908, 85004756, 42667331, 21354465,
        10679838, 5340244, 2670159, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861
    };

    typedef struct packed {
        logic [21:0] x;
        logic [21:0] y;
        logic        face;
        logic        found;
    } hit_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [71:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;
    logic [1:0]  m_tuser;

    bit     wall_bits [MAP_N*MAP_N];
    hit_t   pending_hits [$];
    int     errors;
    longint cycles;
    int     send_idle_pct;
    int     recv_idle_pct;

    grid_ray_march u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Count cycles and abort on a hang
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Random backpressure on the result side
    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= recv_idle_pct);

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $time, msg);
        errors++;
    endtask

    // Unit direction vector in Q2.30 from an angle index
    task automatic ray_direction(input logic [11:0] ang, output longint cs,
                                 output longint sn);
        logic [31:0] phase;
        logic [31:0] shifted;
        logic [1:0]  quad;
        longint      z, x, y, t;
        phase   = {ang, 20'b0};
        shifted = phase + 32'h2000_0000;
        quad    = shifted[31:30];
        z = longint'({2'b0, shifted[29:0]}) - 64'sh2000_0000;
        x = GAIN;
        y = 0;
        if (z == 0)
            x = 64'sd1 << 30;
        else
        begin
            for (int i = 0; i < 16; i++)
            begin
                if (z >= 0)
                begin
                    t = x - (y >>> i);
                    y = y + (x >>> i);
                    z -= ARC_TURNS[i];
                end
                else
                begin
                    t = x + (y >>> i);
                    y = y - (x >>> i);
                    z += ARC_TURNS[i];
                end
                x = t;
            end
        end
        case (quad)
            2'd0:
            begin
                cs = x;
                sn = y;
            end
            2'd1:
            begin
                cs = -y;
                sn = x;
            end
            2'd2:
            begin
                cs = -x;
                sn = -y;
            end
            default:
            begin
                cs = y;
                sn = -x;
            end
        endcase
    endtask

    function automatic bit on_map(longint cx, longint cy);
        return cx >= 0 && cy >= 0 && cx < MAP_N && cy < MAP_N;
    endfunction

    function automatic logic [21:0] clamp_pos(longint v);
        if (v < 0)
            return '0;
        if (v > POS_MAX)
            return 22'h3F_FFFF;
        return v[21:0];
    endfunction

    // Walk the ray border to border until a wall, the map edge or the limit
    task automatic march_ray(input logic [21:0] sx, input logic [21:0] sy,
                             input logic [11:0] ang, output hit_t res);
        longint px, py, c, s, nx, ny, dx, dy, ax, ay, bx, by, cx, cy;
        bit     found;
        bit     face;
        int     steps;
        found = 1'b0;
        face  = 1'b0;
        steps = 0;
        px = longint'(sx);
        py = longint'(sy);
        ray_direction(ang, c, s);
        while (steps < STEP_LIMIT)
        begin
            steps++;
            bx = (px >>> FRAC_BITS) * UNIT;
            by = (py >>> FRAC_BITS) * UNIT;
            nx = c > 0 ? bx + UNIT : (px != bx ? bx : bx - UNIT);
            ny = s > 0 ? by + UNIT : (py != by ? by : by - UNIT);
            dx = nx - px;
            dy = ny - py;
            ax = (dx < 0 ? -dx : dx) * (s < 0 ? -s : s);
            ay = (dy < 0 ? -dy : dy) * (c < 0 ? -c : c);
            if (c == 0)
                py = ny;
            else if (s == 0 || ax < ay)
            begin
                py += dx * s / c;
                px = nx;
            end
            else if (ax == ay)
            begin
                px = nx;
                py = ny;
            end
            else
            begin
                px += dy * c / s;
                py = ny;
            end
            bx = px >>> FRAC_BITS;
            by = py >>> FRAC_BITS;
            if (px == bx * UNIT)
            begin
                face = 1'b0;
                cx = c <= 0 ? bx - 1 : bx;
                cy = by;
                // exact corner: the cell below the crossing goes first
                if (py == by * UNIT && on_map(cx, by - 1) && wall_bits[(by - 1) * MAP_N + cx])
                begin
                    found = 1'b1;
                    break;
                end
            end
            else
            begin
                face = 1'b1;
                cy = s <= 0 ? by - 1 : by;
                cx = bx;
            end
            if (!on_map(cx, cy))
                break;
            if (wall_bits[cy * MAP_N + cx])
            begin
                found = 1'b1;
                break;
            end
        end
        res.x     = clamp_pos(px);
        res.y     = clamp_pos(py);
        res.face  = face;
        res.found = found;
    endtask

    // Present one item, wait for its transfer, then update the predicted state
    task automatic send_item(input bit op, input logic [21:0] sx, input logic [21:0] sy,
                             input logic [11:0] ang, input logic [5:0] cx,
                             input logic [5:0] cy, input bit wall);
        hit_t res;
        if ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {3'b0, wall, cy, cx, ang, sy, sx};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (op == OP_WRITE)
            wall_bits[cy * MAP_N + cx] = wall;
        else
        begin
            march_ray(sx, sy, ang, res);
            pending_hits.push_back(res);
        end
    endtask

    task automatic cast(input logic [21:0] sx, input logic [21:0] sy, input logic [11:0] ang);
        send_item(OP_CAST, sx, sy, ang, '0, '0, 1'b0);
    endtask

    task automatic put_cell(input logic [5:0] cx, input logic [5:0] cy, input bit wall);
        send_item(OP_WRITE, 22'($urandom), 22'($urandom), 12'($urandom), cx, cy, wall);
    endtask

    // Hold the input side until every cast has returned
    task automatic drain;
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_hits.size() != 0)
            @(posedge clk);
    endtask

    // Check each result transfer against the oldest prediction
    always @(posedge clk)
    begin
        hit_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_hits.size() == 0)
                report_mismatch("result with nothing pending");
            else
            begin
                want = pending_hits.pop_front();
                if (m_tdata[21:0] !== want.x)
                    report_mismatch($sformatf("hit_x %h want %h", m_tdata[21:0], want.x));
                if (m_tdata[43:22] !== want.y)
                    report_mismatch($sformatf("hit_y %h want %h", m_tdata[43:22], want.y));
                if (m_tuser[0] !== want.face)
                    report_mismatch($sformatf("hit_face %b want %b", m_tuser[0], want.face));
                if (m_tuser[1] !== want.found)
                    report_mismatch($sformatf("hit_found %b want %b", m_tuser[1], want.found));
            end
        end
    end

    // Axes, diagonals, range extremes, exact corners and map edges
    task automatic test_directed;
        cast(22'h0, 22'h0, 12'd0);
        cast(22'h3F_FFFF, 22'h3F_FFFF, 12'd2048);
        put_cell(6'd10, 6'd5, 1'b1);
        put_cell(6'd5, 6'd10, 1'b1);
        put_cell(6'd63, 6'd63, 1'b1);
        put_cell(6'd0, 6'd0, 1'b1);
        cast({6'd2, 16'h0}, {6'd5, 16'h8000}, 12'd0);
        cast({6'd5, 16'h8000}, {6'd2, 16'h0}, 12'd1024);
        cast({6'd20, 16'h0}, {6'd20, 16'h0}, 12'd2048);
        cast({6'd20, 16'h0}, {6'd20, 16'h0}, 12'd3072);
        cast({6'd60, 16'h0}, {6'd60, 16'h0}, 12'd512);
        cast({6'd3, 16'h0}, {6'd3, 16'h0}, 12'd2560);
        cast({6'd1, 16'h0}, {6'd1, 16'h0}, 12'd2560);
        cast({6'd8, 16'h1234}, {6'd3, 16'hFFFF}, 12'd4095);
        cast({6'd8, 16'h1234}, {6'd3, 16'h0001}, 12'd1);
        cast({6'd62, 16'hFFFF}, {6'd62, 16'hFFFF}, 12'd512);
        put_cell(6'd0, 6'd0, 1'b0);
        cast({6'd3, 16'h0}, {6'd3, 16'h0}, 12'd2560);
        cast(22'h3F_FFFF, 22'h0, 12'd1536);
        cast(22'h0, 22'h3F_FFFF, 12'd3584);
        put_cell(6'd63, 6'd63, 1'b0);
        drain();
    endtask

    // Mostly casts into a map that fills with walls as the run goes on
    task automatic test_random(input int count, input int s_idle, input int r_idle);
        logic [21:0] sx, sy;
        send_idle_pct = s_idle;
        recv_idle_pct = r_idle;
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(99) < 30)
                put_cell(6'($urandom), 6'($urandom), $urandom_range(99) < 75);
            else
            begin
                sx = 22'($urandom);
                sy = 22'($urandom);
                if ($urandom_range(3) == 0)
                    sx[15:0] = '0;
                if ($urandom_range(3) == 0)
                    sy[15:0] = '0;
                if ($urandom_range(7) == 0)
                    cast(sx, sy, 12'($urandom_range(7) * 512));
                else
                    cast(sx, sy, 12'($urandom));
            end
        end
        drain();
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tuser       = 1'b0;
        s_tdata       = '0;
        m_tready      = 1'b0;
        errors        = 0;
        cycles        = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        foreach (wall_bits[i])
            wall_bits[i] = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_random(160, 12, 85);
        test_random(160, 85, 12);
        test_random(160, 0, 0);

        repeat (100) @(posedge clk);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule

### sim.f
sv/grm_pkg.sv
sv/grm_ctrl.sv
sv/grm_dpath.sv
sv/grid_ray_march.sv
bench/tb.sv
